FILE: hw/rtl/htq_pkg.sv
// Shared types and constants for the terrain height query block.
`timescale 1ns / 1ps
`default_nettype none

package htq_pkg;

	localparam int DivW     = 24;
	localparam int DivSteps = 24;
	localparam int CntW     = 5;
	localparam int GW       = 27;
	localparam int IdxW     = 30;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] REG_VERTS_PER_ROW = 2'd0;
	localparam logic [1:0] REG_VERTS_PER_COL = 2'd1;
	localparam logic [1:0] REG_CELL_SPACING  = 2'd2;
	localparam logic [1:0] REG_HEIGHT_SCALE  = 2'd3;

	localparam logic [8:0]  RST_VERTS_PER_ROW = 9'd256;
	localparam logic [8:0]  RST_VERTS_PER_COL = 9'd256;
	localparam logic [7:0]  RST_CELL_SPACING  = 8'd1;
	localparam logic [15:0] RST_HEIGHT_SCALE  = 16'd256;

	localparam logic [1:0] READ_LAST  = 2'd3;
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [1:0] {
		CORNER_A,
		CORNER_B,
		CORNER_C,
		CORNER_D
	} corner_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_FIX,
		ST_SETUP,
		ST_READ,
		ST_DRAIN,
		ST_FDIV_LOAD,
		ST_FDIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [8:0]  verts_per_row;
		logic [8:0]  verts_per_col;
		logic [7:0]  cell_spacing;
		logic [15:0] height_scale;
	} cfg_t;

	typedef struct packed {
		logic    load_we;
		logic    capture;
		logic    div_load;
		logic    div_step;
		logic    fix;
		logic    setup;
		logic    rd_issue;
		corner_t rd_corner;
		logic    fdiv_load;
		logic    finish;
	} cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/htq_div.sv
// Restoring divider by an 8-bit divisor, one quotient bit per step.
`timescale 1ns / 1ps
`default_nettype none

module htq_div (
	input  wire logic                     clk,
	input  wire logic                     load,
	input  wire logic                     step,
	input  wire logic [htq_pkg::DivW-1:0] dividend,
	input  wire logic [7:0]               rem_init,
	input  wire logic [7:0]               divisor,
	output logic      [htq_pkg::DivW-1:0] quot,
	output logic      [7:0]               rem
);

	localparam int DW = htq_pkg::DivW;

	logic [DW-1:0] quo_q;
	logic [7:0]    rem_q;
	logic [8:0]    trial;
	logic [8:0]    diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= rem_init;
		end else if (step) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[7:0] : trial[7:0];
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/htq_regs.sv
// APB configuration registers of the terrain height query block.
`timescale 1ns / 1ps
`default_nettype none

module htq_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output htq_pkg::cfg_t      cfg
);

	htq_pkg::cfg_t cfg_q;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.verts_per_row <= htq_pkg::RST_VERTS_PER_ROW;
			cfg_q.verts_per_col <= htq_pkg::RST_VERTS_PER_COL;
			cfg_q.cell_spacing  <= htq_pkg::RST_CELL_SPACING;
			cfg_q.height_scale  <= htq_pkg::RST_HEIGHT_SCALE;
		end else if (wr) begin
			case (paddr[3:2])
				htq_pkg::REG_VERTS_PER_ROW: cfg_q.verts_per_row <= pwdata[8:0];
				htq_pkg::REG_VERTS_PER_COL: cfg_q.verts_per_col <= pwdata[8:0];
				htq_pkg::REG_CELL_SPACING:  cfg_q.cell_spacing  <= pwdata[7:0];
				htq_pkg::REG_HEIGHT_SCALE:  cfg_q.height_scale  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			htq_pkg::REG_VERTS_PER_ROW: prdata = {23'd0, cfg_q.verts_per_row};
			htq_pkg::REG_VERTS_PER_COL: prdata = {23'd0, cfg_q.verts_per_col};
			htq_pkg::REG_CELL_SPACING:  prdata = {24'd0, cfg_q.cell_spacing};
			htq_pkg::REG_HEIGHT_SCALE:  prdata = {16'd0, cfg_q.height_scale};
			default:                    prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/htq_ctrl.sv
// Controller state machine sequencing loads and height queries.
`timescale 1ns / 1ps
`default_nettype none

module htq_ctrl (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire logic   action,
	output logic        busy,
	output htq_pkg::cmd_t cmd
);

	localparam int CntW = htq_pkg::CntW;

	htq_pkg::state_t state_q, state_n;
	logic [CntW-1:0] cnt_q;
	logic            accept;
	logic            div_last;

	assign busy     = state_q != htq_pkg::ST_IDLE;
	assign accept   = start && !busy;
	assign div_last = cnt_q == CntW'(htq_pkg::DivSteps - 1);

	always_comb begin
		state_n = state_q;
		case (state_q)
			htq_pkg::ST_IDLE: begin
				if (accept && action == htq_pkg::ACT_QUERY) state_n = htq_pkg::ST_DIV_LOAD;
			end
			htq_pkg::ST_DIV_LOAD: state_n = htq_pkg::ST_DIV;
			htq_pkg::ST_DIV: begin
				if (div_last) state_n = htq_pkg::ST_FIX;
			end
			htq_pkg::ST_FIX:   state_n = htq_pkg::ST_SETUP;
			htq_pkg::ST_SETUP: state_n = htq_pkg::ST_READ;
			htq_pkg::ST_READ: begin
				if (cnt_q[1:0] == htq_pkg::READ_LAST) state_n = htq_pkg::ST_DRAIN;
			end
			htq_pkg::ST_DRAIN: begin
				if (cnt_q[1:0] == htq_pkg::DRAIN_LAST) state_n = htq_pkg::ST_FDIV_LOAD;
			end
			htq_pkg::ST_FDIV_LOAD: state_n = htq_pkg::ST_FDIV;
			htq_pkg::ST_FDIV: begin
				if (div_last) state_n = htq_pkg::ST_DONE;
			end
			htq_pkg::ST_DONE: state_n = htq_pkg::ST_IDLE;
			default:          state_n = htq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.rd_corner = htq_pkg::corner_t'(cnt_q[1:0]);
		case (state_q)
			htq_pkg::ST_IDLE: begin
				cmd.load_we = accept && action == htq_pkg::ACT_LOAD;
				cmd.capture = accept && action == htq_pkg::ACT_QUERY;
			end
			htq_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
			htq_pkg::ST_DIV:       cmd.div_step  = 1'b1;
			htq_pkg::ST_FIX:       cmd.fix       = 1'b1;
			htq_pkg::ST_SETUP:     cmd.setup     = 1'b1;
			htq_pkg::ST_READ:      cmd.rd_issue  = 1'b1;
			htq_pkg::ST_FDIV_LOAD: cmd.fdiv_load = 1'b1;
			htq_pkg::ST_FDIV:      cmd.div_step  = 1'b1;
			htq_pkg::ST_DONE:      cmd.finish    = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htq_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= (state_n != state_q) ? '0 : cnt_q + CntW'(1);
		end
	end

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == htq_pkg::ACT_QUERY |=> state_q == htq_pkg::ST_DIV_LOAD)
		else $error("query item did not start the division");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htq_pkg::ST_DIV || state_q == htq_pkg::ST_FDIV)
		|-> cnt_q < CntW'(htq_pkg::DivSteps))
		else $error("division step count overran");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy)
		else $error("block still busy after result");

endmodule

`default_nettype wire

FILE: hw/rtl/htq_dp.sv
// Datapath: height store, grid mapping, corner reads and interpolation.
`timescale 1ns / 1ps
`default_nettype none

module htq_dp #(
	parameter int STORE_DEPTH = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire htq_pkg::cfg_t      cfg,
	input  wire htq_pkg::cmd_t      cmd,
	input  wire logic [15:0]        load_index,
	input  wire logic [7:0]         load_value,
	input  wire logic signed [23:0] query_x,
	input  wire logic signed [23:0] query_z,
	output logic      [23:0]        height,
	output logic                    done
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int GW   = htq_pkg::GW;
	localparam int IdxW = htq_pkg::IdxW;
	localparam int DW   = htq_pkg::DivW;

	logic [15:0] mem [STORE_DEPTH];

	logic [7:0]        cs_eff;
	logic signed [9:0] vrm1, vcm1, vr_s;
	logic signed [8:0] cse;
	logic signed [18:0] wx, wz;
	logic signed [25:0] wx128, wz128;
	logic signed [GW-1:0] gx_q, gz_q;
	logic              negx, negz;
	logic [17:0]       mx, mz;

	logic [DW-1:0] div0_dividend, quot0, quot1;
	logic [7:0]    div0_rem_init, rem0, rem1;
	logic          div0_load;

	logic signed [19:0] col_q, row_q;
	logic [15:0]        rx_q, rz_q;
	logic [7:0]         remx, remz;

	logic [15:0]  s_w;
	logic [16:0]  sum;
	logic         lower;
	logic [16:0]  wa_n, wd_n;
	logic [15:0]  wa_q, wb_q, wc_q, wd_q;
	logic signed [IdxW-1:0] base_q;
	logic [17:0]  area;
	logic [17:0]  size_q;

	logic [10:0]  off;
	logic signed [IdxW-1:0] idx;
	logic [AW-1:0] addr_s1;
	logic          ok_s1, ok_s2;
	logic          v_s1, v_s2, v_s3;
	htq_pkg::corner_t corner_s1, corner_s2;
	logic [15:0]   rdata_s2;
	logic [15:0]   rd_val;
	logic [15:0]   wsel;
	logic [31:0]   prod_n, prod_s3;
	logic [31:0]   acc_q;

	logic [23:0]   scaled;
	logic          wr_en;
	logic [23:0]   height_q;
	logic          done_q;

	// grid origin offsets
	assign cs_eff = (cfg.cell_spacing == 8'd0) ? 8'd1 : cfg.cell_spacing;
	assign cse    = $signed({1'b0, cs_eff});
	assign vr_s   = $signed({1'b0, cfg.verts_per_row});
	assign vrm1   = vr_s - 10'sd1;
	assign vcm1   = $signed({1'b0, cfg.verts_per_col}) - 10'sd1;
	assign wx     = vrm1 * cse;
	assign wz     = vcm1 * cse;
	assign wx128  = {wx, 7'd0};
	assign wz128  = {wz, 7'd0};

	// floor division by spacing on magnitudes
	assign negx = gx_q[GW-1];
	assign negz = gz_q[GW-1];
	assign mx   = negx ? ~gx_q[GW-2:8] : gx_q[GW-2:8];
	assign mz   = negz ? ~gz_q[GW-2:8] : gz_q[GW-2:8];

	assign div0_load     = cmd.div_load || cmd.fdiv_load;
	assign div0_dividend = cmd.fdiv_load ? acc_q[DW-1:0] : {{(DW - 18){1'b0}}, mx};
	assign div0_rem_init = cmd.fdiv_load ? acc_q[31:DW] : 8'd0;

	htq_div u_div_x (
		.clk      (clk),
		.load     (div0_load),
		.step     (cmd.div_step),
		.dividend (div0_dividend),
		.rem_init (div0_rem_init),
		.divisor  (cs_eff),
		.quot     (quot0),
		.rem      (rem0)
	);

	htq_div u_div_z (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend ({{(DW - 18){1'b0}}, mz}),
		.rem_init (8'd0),
		.divisor  (cs_eff),
		.quot     (quot1),
		.rem      (rem1)
	);

	assign remx = negx ? (cs_eff - 8'd1 - rem0) : rem0;
	assign remz = negz ? (cs_eff - 8'd1 - rem1) : rem1;

	// triangle weights
	assign s_w   = {cs_eff, 8'd0};
	assign sum   = {1'b0, rx_q} + {1'b0, rz_q};
	assign lower = sum < {1'b0, s_w};
	assign wa_n  = {1'b0, s_w} - sum;
	assign wd_n  = sum - {1'b0, s_w};
	assign area  = cfg.verts_per_row * cfg.verts_per_col;

	// corner address
	always_comb begin
		case (cmd.rd_corner)
			htq_pkg::CORNER_A: off = 11'd0;
			htq_pkg::CORNER_B: off = 11'd1;
			htq_pkg::CORNER_C: off = {2'd0, cfg.verts_per_row};
			htq_pkg::CORNER_D: off = {2'd0, cfg.verts_per_row} + 11'd1;
			default:           off = 11'd0;
		endcase
	end

	assign idx = base_q + $signed({{(IdxW - 11){1'b0}}, off});

	always_comb begin
		case (corner_s2)
			htq_pkg::CORNER_A: wsel = wa_q;
			htq_pkg::CORNER_B: wsel = wb_q;
			htq_pkg::CORNER_C: wsel = wc_q;
			htq_pkg::CORNER_D: wsel = wd_q;
			default:           wsel = 16'd0;
		endcase
	end

	assign rd_val = ok_s2 ? rdata_s2 : 16'd0;
	assign prod_n = rd_val * wsel;

	assign scaled = load_value * cfg.height_scale;
	assign wr_en  = cmd.load_we && ({1'b0, load_index} < 17'(STORE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) mem[load_index[AW-1:0]] <= scaled[23:8];
		rdata_s2 <= mem[addr_s1];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gx_q <= GW'(wx128) + GW'(query_x);
			gz_q <= GW'(wz128) - GW'(query_z);
		end
		if (cmd.fix) begin
			col_q <= negx ? ~{1'b0, quot0[18:0]} : {1'b0, quot0[18:0]};
			row_q <= negz ? ~{1'b0, quot1[18:0]} : {1'b0, quot1[18:0]};
			rx_q  <= {remx, gx_q[7:0]};
			rz_q  <= {remz, gz_q[7:0]};
		end
		if (cmd.setup) begin
			wa_q   <= lower ? wa_n[15:0] : 16'd0;
			wb_q   <= lower ? rx_q : s_w - rz_q;
			wc_q   <= lower ? rz_q : s_w - rx_q;
			wd_q   <= lower ? 16'd0 : wd_n[15:0];
			base_q <= row_q * vr_s + IdxW'(col_q);
			size_q <= (area > 18'(STORE_DEPTH)) ? 18'(STORE_DEPTH) : area;
			acc_q  <= 32'd0;
		end else if (v_s3) begin
			acc_q <= acc_q + prod_s3;
		end
		addr_s1   <= idx[AW-1:0];
		ok_s1     <= !idx[IdxW-1] && (idx < $signed({{(IdxW - 18){1'b0}}, size_q}));
		corner_s1 <= cmd.rd_corner;
		ok_s2     <= ok_s1;
		corner_s2 <= corner_s1;
		prod_s3   <= prod_n;
		if (cmd.finish) height_q <= quot0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.rd_issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= cmd.finish;
		end
	end

	assign height = height_q;
	assign done   = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

FILE: hw/rtl/heightmap_triangle_height_query.sv
// Top level of the terrain height query block.
`timescale 1ns / 1ps
`default_nettype none

// Terrain height query.
// An item is taken on start while busy is low. With action low it is a load:
// load_value is scaled by height_scale (8.8) and written at load_index in the
// same cycle; a load gives no result and leaves busy low.
// With action high it is a query at (query_x, query_z); the height comes out on
// height with done high for one cycle, as busy falls.
// A query runs two passes of a one-bit-per-step divider by the cell spacing
// (24 steps each: grid mapping, then the final normalize), plus four
// pipelined reads of the height store.
// Results cannot be held off; done is a one-cycle strobe.
// Configuration is written over APB at byte addresses 0, 4, 8, 12; the user
// must write it while idle, as the block itself does not enforce this.
// Reset returns the registers to their defaults and the controller to idle;
// the height store is not cleared, and entries must be loaded before use.
module heightmap_triangle_height_query #(
	parameter int STORE_DEPTH = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [15:0]        load_index,
	input  wire logic [7:0]         load_value,
	input  wire logic signed [23:0] query_x,
	input  wire logic signed [23:0] query_z,
	output logic                    done,
	output logic      [23:0]        height
);

	htq_pkg::cfg_t cfg;
	htq_pkg::cmd_t cmd;

	htq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	htq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.cmd    (cmd)
	);

	htq_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.load_index (load_index),
		.load_value (load_value),
		.query_x    (query_x),
		.query_z    (query_z),
		.height     (height),
		.done       (done)
	);

endmodule

`default_nettype wire

FILE: tb/heightmap_triangle_height_query_test.sv
// Self-checking testbench for the terrain height query block: loads, queries, register settings.
`timescale 1ns / 1ps

module heightmap_triangle_height_query_test;

	localparam int STORE_DEPTH  = 65536;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic               act;
		logic [15:0]        index;
		logic [7:0]         raw;
		logic signed [23:0] qx;
		logic signed [23:0] qz;
	} terrain_item_t;

	logic          clk     = 1'b0;
	logic          arst_n  = 1'b0;
	logic          psel    = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite  = 1'b0;
	logic [3:0]    paddr   = '0;
	logic [31:0]   pwdata  = '0;
	logic [31:0]   prdata;
	logic          pready;
	logic          start   = 1'b0;
	logic          busy;
	logic          done;
	logic [23:0]   height;
	terrain_item_t cur_item = '0;

	logic [8:0]  vpr_cfg    = htq_pkg::RST_VERTS_PER_ROW;
	logic [8:0]  vpc_cfg    = htq_pkg::RST_VERTS_PER_COL;
	logic [7:0]  cell_cfg   = htq_pkg::RST_CELL_SPACING;
	logic [15:0] hscale_cfg = htq_pkg::RST_HEIGHT_SCALE;

	logic [15:0]   terrain_heights [STORE_DEPTH];
	bit            loaded_map [STORE_DEPTH];
	terrain_item_t pending_items [$];
	logic [23:0]   expected_heights [$];

	bit item_taken   = 1'b0;
	bit sender_idles = 1'b0;
	int idle_left    = 0;
	int quiet_cycles = 0;
	int error_count  = 0;

	heightmap_triangle_height_query dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.action     (cur_item.act),
		.load_index (cur_item.index),
		.load_value (cur_item.raw),
		.query_x    (cur_item.qx),
		.query_z    (cur_item.qz),
		.done       (done),
		.height     (height)
	);

	always #10 clk = ~clk;

	function automatic longint floor_quot(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic void locate_cell(input logic signed [23:0] qx, input logic signed [23:0] qz,
			output longint row, output longint col, output longint rx, output longint rz,
			output longint span);
		longint cs, gx, gz;
		cs   = (cell_cfg == 0) ? 1 : longint'(cell_cfg);
		span = cs * 256;
		gx   = (longint'(vpr_cfg) - 1) * cs * 128 + longint'(qx);
		gz   = (longint'(vpc_cfg) - 1) * cs * 128 - longint'(qz);
		col  = floor_quot(gx, span);
		row  = floor_quot(gz, span);
		rx   = gx - col * span;
		rz   = gz - row * span;
	endfunction

	function automatic longint corner_slot(input longint row, input longint col);
		longint cells_total, slot;
		cells_total = longint'(vpr_cfg) * longint'(vpc_cfg);
		if (cells_total > STORE_DEPTH)
			cells_total = STORE_DEPTH;
		slot = row * longint'(vpr_cfg) + col;
		return (slot < 0 || slot >= cells_total) ? -1 : slot;
	endfunction

	function automatic longint corner_height(input longint row, input longint col);
		longint slot;
		slot = corner_slot(row, col);
		return (slot < 0) ? 0 : longint'(terrain_heights[slot]);
	endfunction

	function automatic logic [23:0] predict_height(input logic signed [23:0] qx,
			input logic signed [23:0] qz);
		longint row, col, rx, rz, span, a, b, c, d, n, h;
		locate_cell(qx, qz, row, col, rx, rz, span);
		a = corner_height(row, col);
		b = corner_height(row, col + 1);
		c = corner_height(row + 1, col);
		d = corner_height(row + 1, col + 1);
		if (rx + rz < span)
			n = a * span + (b - a) * rx + (c - a) * rz;
		else
			n = d * span + (c - d) * (span - rx) + (b - d) * (span - rz);
		h = floor_quot(n * 256, span);
		if (h < 0)
			h = 0;
		else if (h > 64'hFFFFFF)
			h = 64'hFFFFFF;
		return h[23:0];
	endfunction

	function automatic void accept_terrain_item(input terrain_item_t item);
		logic [31:0] product;
		if (item.act == htq_pkg::ACT_LOAD) begin
			product = 32'(item.raw) * 32'(hscale_cfg);
			terrain_heights[item.index] = product[23:8];
		end else begin
			expected_heights.push_back(predict_height(item.qx, item.qz));
		end
	endfunction

	function automatic void add_load(input logic [15:0] index, input logic [7:0] raw);
		terrain_item_t item;
		item.act   = htq_pkg::ACT_LOAD;
		item.index = index;
		item.raw   = raw;
		item.qx    = 24'($urandom);
		item.qz    = 24'($urandom);
		pending_items.push_back(item);
		loaded_map[index] = 1'b1;
	endfunction

	// load every in-range corner not yet written so the query never reads stale store
	function automatic void add_query(input logic signed [23:0] qx, input logic signed [23:0] qz);
		terrain_item_t item;
		longint row, col, rx, rz, span, slot;
		locate_cell(qx, qz, row, col, rx, rz, span);
		for (int dr = 0; dr < 2; dr++) begin
			for (int dc = 0; dc < 2; dc++) begin
				slot = corner_slot(row + dr, col + dc);
				if (slot >= 0 && !loaded_map[slot])
					add_load(slot[15:0], 8'($urandom_range(0, 255)));
			end
		end
		item.act   = htq_pkg::ACT_QUERY;
		item.index = 16'($urandom);
		item.raw   = 8'($urandom);
		item.qx    = qx;
		item.qz    = qz;
		pending_items.push_back(item);
	endfunction

	function automatic void add_grid_query();
		longint cs, span, row, col, rx, rz, x, z;
		cs   = (cell_cfg == 0) ? 1 : longint'(cell_cfg);
		span = cs * 256;
		col  = longint'($urandom_range(0, vpr_cfg + 1)) - 1;
		row  = longint'($urandom_range(0, vpc_cfg + 1)) - 1;
		rx   = longint'($urandom_range(0, span - 1));
		if ($urandom_range(0, 7) == 0 && rx != 0)
			rz = span - rx;
		else
			rz = longint'($urandom_range(0, span - 1));
		x = col * span + rx - (longint'(vpr_cfg) - 1) * cs * 128;
		z = (longint'(vpc_cfg) - 1) * cs * 128 - (row * span + rz);
		if (x > 8388607)
			x = 8388607;
		else if (x < -8388608)
			x = -8388608;
		if (z > 8388607)
			z = 8388607;
		else if (z < -8388608)
			z = -8388608;
		add_query(x[23:0], z[23:0]);
	endfunction

	function automatic void add_random_items(input int count);
		repeat (count) begin
			case ($urandom_range(0, 9))
				0: add_load(16'($urandom_range(0, STORE_DEPTH - 1)), 8'($urandom_range(0, 255)));
				1: add_load(16'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
				2: add_query(24'($urandom), 24'($urandom));
				default: add_grid_query();
			endcase
		end
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || start || busy || expected_heights.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] reg_sel, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_sel, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk);
		while (!pready);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata !== value) begin
			$display("%0t: register %0d readback: expected %0h, actual %0h",
				$time, reg_sel, value, prdata);
			error_count++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		case (reg_sel)
			htq_pkg::REG_VERTS_PER_ROW: vpr_cfg    = value[8:0];
			htq_pkg::REG_VERTS_PER_COL: vpc_cfg    = value[8:0];
			htq_pkg::REG_CELL_SPACING:  cell_cfg   = value[7:0];
			htq_pkg::REG_HEIGHT_SCALE:  hscale_cfg = value[15:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input int vpr, input int vpc, input int cs, input int scale,
			input int count, input bit idles);
		wait_idle();
		write_register(htq_pkg::REG_VERTS_PER_ROW, 32'(vpr));
		write_register(htq_pkg::REG_VERTS_PER_COL, 32'(vpc));
		write_register(htq_pkg::REG_CELL_SPACING, 32'(cs));
		write_register(htq_pkg::REG_HEIGHT_SCALE, 32'(scale));
		sender_idles = idles;
		@(posedge clk);
		add_random_items(count);
	endtask

	always @(negedge clk) begin
		if (arst_n && !(start && !item_taken)) begin
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start     <= 1'b0;
			end else if (pending_items.size() != 0 && sender_idles && $urandom_range(0, 3) == 0) begin
				idle_left <= $urandom_range(0, 4);
				start     <= 1'b0;
			end else if (pending_items.size() != 0) begin
				cur_item <= pending_items.pop_front();
				start    <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		logic [23:0] want;
		item_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (expected_heights.size() == 0) begin
					$display("%0t: height result: expected none, actual %0d", $time, height);
					error_count++;
				end else begin
					want = expected_heights.pop_front();
					if (height !== want) begin
						$display("%0t: height: expected %0d, actual %0d", $time, want, height);
						error_count++;
					end
				end
			end
			if (start && !busy)
				accept_terrain_item(cur_item);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("heightmap_triangle_height_query_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		sender_idles = 1'b1;
		@(posedge clk);

		add_load(0, 255);
		add_load(STORE_DEPTH - 1, 255);
		add_load(1, 0);
		add_load(256, 128);
		add_load(257, 1);
		add_query(-32640, 32640);
		add_query(-32640 + 128, 32640 - 64);
		add_query(-32640 + 200, 32640 - 200);
		add_query(-32640 + 128, 32640 - 128);
		add_query(0, 0);
		add_query(32640, -32640);
		add_query(32639, -32639);
		add_query(-32641, 32640);
		add_query(32640, 32640);
		add_query(-32640, 32641);
		add_query(8388607, 8388607);
		add_query(-8388608, -8388608);
		add_query(8388607, -8388608);
		add_query(-8388608, 8388607);
		add_random_items(10);

		run_phase(2, 2, 255, 65535, 15, 1'b1);
		run_phase(256, 256, 255, 0, 15, 1'b0);
		run_phase(1, 256, 0, 1, 15, 1'b1);
		run_phase(200, 1, 7, $urandom_range(1, 65535), 15, 1'b1);
		run_phase(0, 0, 3, $urandom_range(0, 65535), 5, 1'b1);
		run_phase(511, 300, 3, $urandom_range(0, 65535), 15, 1'b1);
		run_phase($urandom_range(2, 24), $urandom_range(2, 24), $urandom_range(1, 16),
			$urandom_range(0, 65535), 20, 1'b1);
		run_phase($urandom_range(2, 256), $urandom_range(2, 256), $urandom_range(1, 255),
			$urandom_range(0, 65535), 30, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("heightmap_triangle_height_query_test OK");
		else
			$display("heightmap_triangle_height_query_test NOT OK");
		$finish;
	end

endmodule

FILE: heightmap_triangle_height_query.f
hw/rtl/htq_pkg.sv
hw/rtl/htq_div.sv
hw/rtl/htq_regs.sv
hw/rtl/htq_ctrl.sv
hw/rtl/htq_dp.sv
hw/rtl/heightmap_triangle_height_query.sv
tb/heightmap_triangle_height_query_test.sv
